FILE: rtl/core/agrt_pkg.sv
// ----------------------------------------------------------------------------
// agrt_pkg - shared definitions for the ARP responder with address table
// Field widths, protocol constants, result kinds and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package agrt_pkg;

    localparam int unsigned TableEntries = 256;
    localparam int unsigned IdxW         = $clog2(TableEntries);
    localparam int unsigned MacW         = 48;
    localparam int unsigned IpW          = 32;

    localparam int unsigned InDataW  = 248;
    localparam int unsigned OutDataW = 176;
    localparam int unsigned OutUserW = 4;
    localparam int unsigned CfgIdxW  = 2;

    localparam logic [15:0]   EthIp          = 16'h0800;
    localparam logic [15:0]   EthArp         = 16'h0806;
    localparam logic [55:0]   ArpFixedHeader = 56'h00_01_08_00_06_04_00;
    localparam logic [7:0]    OpRequest      = 8'h01;
    localparam logic [7:0]    OpReply        = 8'h02;
    localparam logic [7:0]    OctetBcast     = 8'hff;
    localparam logic [IpW-1:0] NetMaskReset  = 32'hffff_ff00;
    localparam logic [MacW-1:0] MacBcast     = '1;

    typedef enum logic [2:0] {
        KIND_IP_PASS   = 3'd0,
        KIND_ABSORBED  = 3'd1,
        KIND_REPLY     = 3'd2,
        KIND_MALFORMED = 3'd3,
        KIND_BAD_OP    = 3'd4,
        KIND_DISCARD   = 3'd5,
        KIND_LOOKUP    = 3'd6
    } t_kind;

    typedef enum logic [CfgIdxW-1:0] {
        REG_OWN_MAC  = 2'd0,
        REG_OWN_IP   = 2'd1,
        REG_NET_MASK = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

FILE: rtl/core/arp_glean_reply_table_core.sv
// ----------------------------------------------------------------------------
// arp_glean_reply_table_core - ARP responder with a gleaned MAC address table
// Classifies received frame headers, learns ARP senders into a 256-entry
// table, answers requests for the own IP and looks up outgoing MACs.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one parsed header per transaction (tuser = mode: 0 received
//   frame, 1 destination lookup). m_axis returns exactly one result for each.
//   The config channel (i_cfg_*) writes own_mac, own_ip and net_mask; write
//   it only while no transaction is in flight. o_cfg_ready is always high.
//   Items pass the middle stage and the output register. One transaction
//   per cycle is taken while s_axis_tready is high: the single table port is
//   either read (lookup) or written (learn) in the accept cycle, so an item
//   needs one port access and a learn is visible to the very next item.
//   Reset clears per-entry valid bits, so every entry but the own index reads
//   as broadcast at once; no clearing pass is needed. Reset also clears the
//   own-entry flag and loads the register defaults (net_mask = 255.255.255.0).
//   When m_axis stalls, the output register holds, then the middle stage
//   fills and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_glean_reply_table_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // config write channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [agrt_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [47:0]                  i_cfg_data,
    // input stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // ether_type, arp_header, arp_opcode, frame_src_mac, sender_mac,
    // sender_ip, target_ip, lookup_octet
    input  wire logic [agrt_pkg::InDataW-1:0] s_axis_tdata,
    input  wire logic                         s_axis_tuser,   // mode
    // result stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // reply_dst_mac, reply_target_mac, reply_target_ip, lookup_mac
    output logic [agrt_pkg::OutDataW-1:0]     m_axis_tdata,
    output logic [agrt_pkg::OutUserW-1:0]     m_axis_tuser    // result_kind, learned
);

    import agrt_pkg::*;

    // configuration
    logic [MacW-1:0] r_own_mac;
    logic [IpW-1:0]  r_own_ip;
    logic [IpW-1:0]  r_net_mask;
    logic            r_own_learned;

    // table storage and per-entry valid bits
    logic [MacW-1:0] r_mem [0:TableEntries-1];
    logic [TableEntries-1:0] r_valid;
    logic [MacW-1:0] r_rd_data;

    // input field decode
    logic            in_mode;
    logic [15:0]     in_ether_type;
    logic [55:0]     in_arp_header;
    logic [7:0]      in_arp_opcode;
    logic [MacW-1:0] in_frame_src_mac;
    logic [MacW-1:0] in_sender_mac;
    logic [IpW-1:0]  in_sender_ip;
    logic [IpW-1:0]  in_target_ip;
    logic [IdxW-1:0] in_lookup_octet;

    // middle stage
    logic            r_s1_vld;
    t_kind           r_s1_kind;
    logic            r_s1_learned;
    logic [MacW-1:0] r_s1_rdst;
    logic [MacW-1:0] r_s1_rtmac;
    logic [IpW-1:0]  r_s1_rtip;
    logic            r_s1_own;
    logic            r_s1_entry_vld;

    // output register
    logic            r_out_vld;
    t_kind           r_out_kind;
    logic            r_out_learned;
    logic [MacW-1:0] r_out_rdst;
    logic [MacW-1:0] r_out_rtmac;
    logic [IpW-1:0]  r_out_rtip;
    logic [MacW-1:0] r_out_lmac;

    logic            accept;
    logic            s1_adv;
    logic            cfg_wr;
    logic            cfg_own_ip_wr;
    t_kind           n_kind;
    logic            hdr_ok;
    logic            learn_ok;
    logic            wr_en;
    logic            rd_en;
    logic [IdxW-1:0] wr_idx;
    logic [IdxW-1:0] own_idx;
    logic [MacW-1:0] s1_lmac;

    assign in_mode          = s_axis_tuser;
    assign in_ether_type    = s_axis_tdata[15:0];
    assign in_arp_header    = s_axis_tdata[71:16];
    assign in_arp_opcode    = s_axis_tdata[79:72];
    assign in_frame_src_mac = s_axis_tdata[127:80];
    assign in_sender_mac    = s_axis_tdata[175:128];
    assign in_sender_ip     = s_axis_tdata[207:176];
    assign in_target_ip     = s_axis_tdata[239:208];
    assign in_lookup_octet  = s_axis_tdata[247:240];

    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid;
    assign cfg_own_ip_wr = cfg_wr && (i_cfg_index == REG_OWN_IP);

    assign s1_adv        = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_s1_vld || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign own_idx = r_own_ip[IdxW-1:0];
    assign wr_idx  = in_sender_ip[IdxW-1:0];
    assign hdr_ok  = (in_arp_header == ArpFixedHeader);

    always_comb begin
        learn_ok = (in_sender_ip != '0)
                && (in_sender_ip[7:0] != OctetBcast)
                && ((in_sender_ip & r_net_mask) == (r_own_ip & r_net_mask));
        if (in_mode) begin
            n_kind = KIND_LOOKUP;
        end else if (in_ether_type == EthIp) begin
            n_kind = KIND_IP_PASS;
        end else if (in_ether_type != EthArp) begin
            n_kind = KIND_DISCARD;
        end else if (!hdr_ok) begin
            n_kind = KIND_MALFORMED;
        end else if (in_arp_opcode == OpReply) begin
            n_kind = KIND_ABSORBED;
        end else if (in_arp_opcode == OpRequest) begin
            n_kind = (in_target_ip == r_own_ip) ? KIND_REPLY : KIND_ABSORBED;
        end else begin
            n_kind = KIND_BAD_OP;
        end
    end

    assign wr_en = accept && learn_ok
                && (n_kind == KIND_ABSORBED || n_kind == KIND_REPLY);
    assign rd_en = accept && in_mode;

    // table port: at most one write or one read per accepted item
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= in_sender_mac;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[in_lookup_octet];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac     <= '0;
            r_own_ip      <= '0;
            r_net_mask    <= NetMaskReset;
            r_own_learned <= 1'b0;
            r_valid       <= '0;
            r_s1_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (i_cfg_index)
                    REG_OWN_MAC:  r_own_mac  <= i_cfg_data;
                    REG_OWN_IP:   r_own_ip   <= i_cfg_data[IpW-1:0];
                    REG_NET_MASK: r_net_mask <= i_cfg_data[IpW-1:0];
                    default:      ;
                endcase
            end
            if (cfg_own_ip_wr) begin
                r_own_learned <= 1'b0;
            end else if (wr_en && (wr_idx == own_idx)) begin
                r_own_learned <= 1'b1;
            end
            if (wr_en) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if (s_axis_tready) begin
                r_s1_vld <= accept;
            end
            if (s1_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // middle stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind      <= n_kind;
            r_s1_learned   <= wr_en;
            r_s1_own       <= (in_lookup_octet == own_idx) && !r_own_learned;
            r_s1_entry_vld <= r_valid[in_lookup_octet];
            if (n_kind == KIND_REPLY) begin
                r_s1_rdst  <= in_frame_src_mac;
                r_s1_rtmac <= in_sender_mac;
                r_s1_rtip  <= in_sender_ip;
            end else begin
                r_s1_rdst  <= '0;
                r_s1_rtmac <= '0;
                r_s1_rtip  <= '0;
            end
        end
    end

    always_comb begin
        if (r_s1_kind != KIND_LOOKUP) begin
            s1_lmac = '0;
        end else if (r_s1_own) begin
            s1_lmac = r_own_mac;
        end else if (r_s1_entry_vld) begin
            s1_lmac = r_rd_data;
        end else begin
            s1_lmac = MacBcast;
        end
    end

    // output register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out_kind    <= r_s1_kind;
            r_out_learned <= r_s1_learned;
            r_out_rdst    <= r_s1_rdst;
            r_out_rtmac   <= r_s1_rtmac;
            r_out_rtip    <= r_s1_rtip;
            r_out_lmac    <= s1_lmac;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_lmac, r_out_rtip, r_out_rtmac, r_out_rdst};
    assign m_axis_tuser  = {r_out_learned, r_out_kind};

    // ------------------------------------------------------------------------
    a_learn_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_learned) |->
            (r_out_kind == KIND_ABSORBED || r_out_kind == KIND_REPLY))
        else $error("learned flag on a result that cannot learn");

    a_lmac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_kind != KIND_LOOKUP) |-> (r_out_lmac == '0))
        else $error("lookup MAC set on a non-lookup result");

    a_own_learn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && wr_idx == own_idx && !cfg_own_ip_wr) |=> r_own_learned)
        else $error("own entry flag not set after learning own index");

    a_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_valid[$past(wr_idx)])
        else $error("table entry not marked valid after write");

endmodule

`default_nettype wire

FILE: tb/arp_glean_reply_table_core_tb.sv
// ----------------------------------------------------------------------------
// arp_glean_reply_table_core_tb - self-checking bench for the ARP responder
// Drives parsed frame headers and destination lookups into the core, keeps
// its own copy of the address table and registers, and checks every result
// field by field. The run has a directed table, then random traffic under
// several register settings and handshake pressure patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_glean_reply_table_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import agrt_pkg::*;

    localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;   // no register behind it

    typedef struct packed {
        logic        mode;
        logic [15:0] ether_type;
        logic [55:0] arp_header;
        logic [7:0]  arp_opcode;
        logic [47:0] frame_src_mac;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [7:0]  lookup_octet;
    } t_frame_hdr;

    typedef struct packed {
        t_kind       kind;
        logic        learned;
        logic [47:0] reply_dst;
        logic [47:0] reply_tmac;
        logic [31:0] reply_tip;
        logic [47:0] lookup_mac;
    } t_frame_result;

    typedef struct {
        t_frame_hdr    hdr;
        logic          typed;
        t_frame_result want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_index   = '0;
    logic [47:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic [InDataW-1:0]   s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tready = 1'b0;
    wire logic            o_cfg_ready;
    wire logic            s_axis_tready;
    wire logic            m_axis_tvalid;
    wire logic [OutDataW-1:0] m_axis_tdata;
    wire logic [OutUserW-1:0] m_axis_tuser;

    // bench copy of the core's state and registers
    logic [47:0]   tbl_mac [TableEntries];
    logic [47:0]   own_mac_r;
    logic [31:0]   own_ip_r;
    logic [31:0]   net_mask_r;
    logic          own_entry_set;

    t_frame_result pending_results [$];
    int unsigned   err_count    = 0;
    int unsigned   tx_idle_pct  = 0;
    int unsigned   rx_stall_pct = 0;

    arp_glean_reply_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("arp_glean_reply_table_core test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic t_frame_result glean_and_answer(input t_frame_hdr h);
        t_frame_result r;
        r = '0;
        if (h.mode) begin
            r.kind = KIND_LOOKUP;
            if (h.lookup_octet == own_ip_r[7:0] && !own_entry_set)
                r.lookup_mac = own_mac_r;
            else
                r.lookup_mac = tbl_mac[h.lookup_octet];
        end else if (h.ether_type == EthIp) begin
            r.kind = KIND_IP_PASS;
        end else if (h.ether_type != EthArp) begin
            r.kind = KIND_DISCARD;
        end else if (h.arp_header != ArpFixedHeader) begin
            r.kind = KIND_MALFORMED;
        end else if (h.arp_opcode == OpRequest || h.arp_opcode == OpReply) begin
            r.kind = KIND_ABSORBED;
            // glean only non-zero, non-broadcast senders on the own subnet
            if (h.sender_ip != '0 && h.sender_ip[7:0] != OctetBcast &&
                (h.sender_ip & net_mask_r) == (own_ip_r & net_mask_r)) begin
                tbl_mac[h.sender_ip[7:0]] = h.sender_mac;
                if (h.sender_ip[7:0] == own_ip_r[7:0])
                    own_entry_set = 1'b1;
                r.learned = 1'b1;
            end
            if (h.arp_opcode == OpRequest && h.target_ip == own_ip_r) begin
                r.kind       = KIND_REPLY;
                r.reply_dst  = h.frame_src_mac;
                r.reply_tmac = h.sender_mac;
                r.reply_tip  = h.sender_ip;
            end
        end else begin
            r.kind = KIND_BAD_OP;
        end
        return r;
    endfunction

    function automatic void model_write(input logic [CfgIdxW-1:0] idx,
                                        input logic [47:0] val);
        case (idx)
            REG_OWN_MAC:  own_mac_r = val;
            REG_OWN_IP: begin
                own_ip_r      = val[31:0];
                own_entry_set = 1'b0;
            end
            REG_NET_MASK: net_mask_r = val[31:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic t_frame_hdr hdr_lookup(input logic [7:0] octet);
        t_frame_hdr h;
        h              = '0;
        h.mode         = 1'b1;
        h.lookup_octet = octet;
        return h;
    endfunction

    function automatic t_frame_hdr hdr_eth(input logic [15:0] etype);
        t_frame_hdr h;
        h            = '0;
        h.ether_type = etype;
        return h;
    endfunction

    function automatic t_frame_hdr hdr_arp(input logic [55:0] fixed,
                                           input logic [7:0]  op,
                                           input logic [47:0] src,
                                           input logic [47:0] smac,
                                           input logic [31:0] sip,
                                           input logic [31:0] tip);
        t_frame_hdr h;
        h               = '0;
        h.ether_type    = EthArp;
        h.arp_header    = fixed;
        h.arp_opcode    = op;
        h.frame_src_mac = src;
        h.sender_mac    = smac;
        h.sender_ip     = sip;
        h.target_ip     = tip;
        return h;
    endfunction

    function automatic t_frame_result res(input t_kind kind, input logic learned,
                                          input logic [47:0] lmac);
        t_frame_result r;
        r            = '0;
        r.kind       = kind;
        r.learned    = learned;
        r.lookup_mac = lmac;
        return r;
    endfunction

    // mostly lookups and well-formed ARP traffic aimed at the current subnet, plus noise
    function automatic t_frame_hdr rand_hdr();
        t_frame_hdr  h;
        int unsigned pick;
        h.mode          = 1'b0;
        h.ether_type    = 16'($urandom);
        h.arp_header    = {24'($urandom), $urandom};
        h.arp_opcode    = 8'($urandom);
        h.frame_src_mac = rand48();
        h.sender_mac    = rand48();
        h.sender_ip     = $urandom;
        h.target_ip     = $urandom;
        h.lookup_octet  = 8'($urandom);
        pick            = $urandom_range(99);
        if (pick < 25) begin
            h.mode = 1'b1;
            if ($urandom_range(3) == 0)
                h.lookup_octet = own_ip_r[7:0];
        end else if (pick < 80) begin
            h.ether_type = EthArp;
            h.arp_header = ArpFixedHeader;
            h.arp_opcode = $urandom_range(1) ? OpRequest : OpReply;
            h.sender_ip  = (own_ip_r & net_mask_r) | (h.sender_ip & ~net_mask_r);
            case ($urandom_range(9))
                0: h.sender_ip[7:0] = OctetBcast;
                1: h.sender_ip      = own_ip_r;
                2: h.sender_ip      = '0;
                default: ;
            endcase
            if ($urandom_range(1))
                h.target_ip = own_ip_r;
        end else if (pick < 88) begin
            h.ether_type = EthIp;
        end else if (pick < 96) begin
            h.ether_type = EthArp;
            if ($urandom_range(1))
                h.arp_header = ArpFixedHeader ^ (56'd1 << $urandom_range(55));
            else
                h.arp_header = ArpFixedHeader;
        end
        return h;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_hdr(input t_frame_hdr h, input logic typed,
                            input t_frame_result want);
        int unsigned   gap;
        t_frame_result pred;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= h.mode;
        s_axis_tdata  <= {h.lookup_octet, h.target_ip, h.sender_ip, h.sender_mac,
                          h.frame_src_mac, h.arp_opcode, h.arp_header, h.ether_type};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        // predict on the transaction edge so table updates keep input order
        pred = glean_and_answer(h);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        model_write(idx, val);
    endtask

    task automatic wait_results();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // upper data bits of the IP and mask writes carry junk the core must drop
    task automatic apply_settings(input logic [47:0] mac, input logic [31:0] ip,
                                  input logic [31:0] mask, input logic poke_spare);
        if (poke_spare)
            set_reg(RegSpare, rand48());
        set_reg(REG_OWN_MAC, mac);
        set_reg(REG_OWN_IP, {16'($urandom), ip});
        set_reg(REG_NET_MASK, {16'($urandom), mask});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int unsigned n, input int unsigned tx_pct,
                              input int unsigned rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (n)
            send_hdr(rand_hdr(), 1'b0, '0);
        s_axis_tvalid <= 1'b0;
        wait_results();
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string fld, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch, got %h expected %h", $realtime, fld, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind    = t_kind'(m_axis_tuser[2:0]);
            got.learned = m_axis_tuser[3];
            {got.lookup_mac, got.reply_tip, got.reply_tmac, got.reply_dst} = m_axis_tdata;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_axis_tuser), '0);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("result_kind", 64'(got.kind), 64'(want.kind));
                if (got.learned !== want.learned)
                    report_mismatch("learned", 64'(got.learned), 64'(want.learned));
                if (got.reply_dst !== want.reply_dst)
                    report_mismatch("reply_dst_mac", 64'(got.reply_dst), 64'(want.reply_dst));
                if (got.reply_tmac !== want.reply_tmac)
                    report_mismatch("reply_target_mac", 64'(got.reply_tmac),
                                    64'(want.reply_tmac));
                if (got.reply_tip !== want.reply_tip)
                    report_mismatch("reply_target_ip", 64'(got.reply_tip), 64'(want.reply_tip));
                if (got.lookup_mac !== want.lookup_mac)
                    report_mismatch("lookup_mac", 64'(got.lookup_mac), 64'(want.lookup_mac));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    localparam logic [47:0] DirOwnMac = 48'h02_11_22_33_44_55;
    localparam logic [31:0] DirOwnIp  = 32'hC0A8_0105;   // 192.168.1.5

    initial begin : stimulus
        t_stim_row  dir_rows [$];
        t_frame_hdr odd;

        for (int i = 0; i < TableEntries; i++)
            tbl_mac[i] = MacBcast;
        own_mac_r     = '0;
        own_ip_r      = '0;
        net_mask_r    = NetMaskReset;
        own_entry_set = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // net mask left at its reset value for the directed table
        set_reg(REG_OWN_MAC, DirOwnMac);
        set_reg(REG_OWN_IP, {16'h0, DirOwnIp});
        i_cfg_valid <= 1'b0;

        dir_rows.push_back('{hdr_lookup(8'h20), 1'b1, res(KIND_LOOKUP, 1'b0, MacBcast)});
        dir_rows.push_back('{hdr_lookup(8'h05), 1'b1, res(KIND_LOOKUP, 1'b0, DirOwnMac)});
        dir_rows.push_back('{hdr_lookup(8'hff), 1'b1, res(KIND_LOOKUP, 1'b0, MacBcast)});
        dir_rows.push_back('{hdr_lookup(8'h00), 1'b1, res(KIND_LOOKUP, 1'b0, MacBcast)});
        dir_rows.push_back('{hdr_eth(EthIp), 1'b1, res(KIND_IP_PASS, 1'b0, '0)});
        dir_rows.push_back('{hdr_eth(16'h0000), 1'b1, res(KIND_DISCARD, 1'b0, '0)});
        dir_rows.push_back('{hdr_eth(16'hffff), 1'b1, res(KIND_DISCARD, 1'b0, '0)});
        dir_rows.push_back('{hdr_arp('1, OpRequest, '1, '1, DirOwnIp + 1, DirOwnIp),
                             1'b1, res(KIND_MALFORMED, 1'b0, '0)});
        dir_rows.push_back('{hdr_arp('0, OpReply, '1, '1, DirOwnIp + 1, DirOwnIp),
                             1'b1, res(KIND_MALFORMED, 1'b0, '0)});
        dir_rows.push_back('{hdr_arp(ArpFixedHeader, 8'h00, '0, '0, DirOwnIp + 1, DirOwnIp),
                             1'b1, res(KIND_BAD_OP, 1'b0, '0)});
        dir_rows.push_back('{hdr_arp(ArpFixedHeader, 8'hff, '0, '0, DirOwnIp + 1, DirOwnIp),
                             1'b1, res(KIND_BAD_OP, 1'b0, '0)});
        dir_rows.push_back('{hdr_arp(ArpFixedHeader, 8'h03, '0, '0, DirOwnIp + 1, DirOwnIp),
                             1'b1, res(KIND_BAD_OP, 1'b0, '0)});
        dir_rows.push_back('{hdr_arp(ArpFixedHeader, OpReply, 48'h0A_0B_0C_0D_0E_0F,
                                     48'h0A_BB_CC_DD_EE_01, 32'hC0A8_0120, 32'h0),
                             1'b1, res(KIND_ABSORBED, 1'b1, '0)});
        dir_rows.push_back('{hdr_lookup(8'h20), 1'b0, '0});
        // request for the own address: reply plus glean of the asker
        dir_rows.push_back('{hdr_arp(ArpFixedHeader, OpRequest, 48'h0C_00_00_00_00_07,
                                     48'h0B_00_00_00_00_07, 32'hC0A8_0107, DirOwnIp),
                             1'b0, '0});
        dir_rows.push_back('{hdr_arp(ArpFixedHeader, OpRequest, 48'h0C_00_00_00_00_08,
                                     48'h0B_00_00_00_00_08, 32'hC0A8_0108, 32'hC0A8_0109),
                             1'b0, '0});
        dir_rows.push_back('{hdr_arp(ArpFixedHeader, OpReply, '1, '1, 32'hC0A8_01FF, '0),
                             1'b1, res(KIND_ABSORBED, 1'b0, '0)});
        dir_rows.push_back('{hdr_arp(ArpFixedHeader, OpReply, '1, '1, 32'h0, '0),
                             1'b1, res(KIND_ABSORBED, 1'b0, '0)});
        dir_rows.push_back('{hdr_arp(ArpFixedHeader, OpReply, '1, '1, 32'hC0A8_0209, '0),
                             1'b1, res(KIND_ABSORBED, 1'b0, '0)});
        // off-subnet asker still gets an answer but is not gleaned
        dir_rows.push_back('{hdr_arp(ArpFixedHeader, OpRequest, '1, '1, 32'h0A00_0001,
                                     DirOwnIp), 1'b0, '0});
        // learning over the own index hides own_mac from lookups
        dir_rows.push_back('{hdr_arp(ArpFixedHeader, OpReply, '0, '0, DirOwnIp, '0),
                             1'b0, '0});
        dir_rows.push_back('{hdr_lookup(8'h05), 1'b0, '0});
        odd              = hdr_arp('1, '1, '1, '1, '1, '1);
        odd.mode         = 1'b1;
        odd.lookup_octet = 8'h07;
        dir_rows.push_back('{odd, 1'b0, '0});
        odd              = hdr_arp(ArpFixedHeader, OpRequest, '1, '1, 32'hC0A8_01FE, DirOwnIp);
        odd.lookup_octet = 8'hff;
        dir_rows.push_back('{odd, 1'b0, '0});

        foreach (dir_rows[k])
            send_hdr(dir_rows[k].hdr, dir_rows[k].typed, dir_rows[k].want);
        s_axis_tvalid <= 1'b0;
        wait_results();

        apply_settings(rand48(), 32'h0A00_0001, 32'hFFFF_FF00, 1'b0);
        run_random(250, 0, 0);
        apply_settings(MacBcast, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        run_random(250, 69, 0);
        apply_settings(48'h0, 32'hC0A8_0A0A, 32'hFFFF_FFFF, 1'b1);
        run_random(250, 0, 69);
        apply_settings(rand48(), $urandom, 32'hFFFF_0000, 1'b0);
        run_random(250, 23, 23);
        apply_settings(rand48(), 32'h0000_0000, NetMaskReset, 1'b0);
        run_random(100, 23, 23);

        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("arp_glean_reply_table_core test passed");
        else
            $display("arp_glean_reply_table_core test failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/agrt_pkg.sv
rtl/core/arp_glean_reply_table_core.sv
tb/arp_glean_reply_table_core_tb.sv
